[rtl/core/ipip_pkg.sv]
// Package for the IPv4-in-IPv4 header prepend block: types, constants and the
// outer header byte table. Used by every module of the block; no dependencies.
package ipip_pkg;

   localparam int unsigned QUEUE_DEPTH_DEF = 4;

   localparam logic [5:0]  HDR_BYTES      = 6'd34;
   localparam logic [15:0] LEN_CAP        = 16'd65501;
   localparam logic [15:0] IP_HDR_LEN     = 16'd20;
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  IPV4_VHL_DEF   = 8'h45;
   localparam logic [7:0]  IP_TTL         = 8'd64;
   localparam logic [7:0]  IP_PROTO_ENCAP = 8'd4;

   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 48;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SRC_MAC     = 3'd0,
      CSR_DST_MAC     = 3'd1,
      CSR_SRC_IP      = 3'd2,
      CSR_DST_IP      = 3'd3,
      CSR_MAX_PAYLOAD = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic [47:0] src_mac;
      logic [47:0] dst_mac;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [15:0] max_payload;
   } cfg_type;

   // hdr set: emit the outer header first, then the byte unless no_payload
   typedef struct packed {
      logic        hdr;
      logic        first_out;
      logic        last;
      logic        enc;
      logic        no_payload;
      logic [7:0]  data;
      logic [15:0] tot;
      logic [15:0] ck;
   } entry_type;

   function automatic logic [7:0] hdr_byte(input logic [5:0] idx, input cfg_type cfg,
                                           input logic [15:0] tot, input logic [15:0] ck);
      logic [7:0] b;
      b = 8'h00;
      case (idx)
         6'd0:  b = cfg.dst_mac[47:40];
         6'd1:  b = cfg.dst_mac[39:32];
         6'd2:  b = cfg.dst_mac[31:24];
         6'd3:  b = cfg.dst_mac[23:16];
         6'd4:  b = cfg.dst_mac[15:8];
         6'd5:  b = cfg.dst_mac[7:0];
         6'd6:  b = cfg.src_mac[47:40];
         6'd7:  b = cfg.src_mac[39:32];
         6'd8:  b = cfg.src_mac[31:24];
         6'd9:  b = cfg.src_mac[23:16];
         6'd10: b = cfg.src_mac[15:8];
         6'd11: b = cfg.src_mac[7:0];
         6'd12: b = ETHERTYPE_IPV4[15:8];
         6'd13: b = ETHERTYPE_IPV4[7:0];
         6'd14: b = IPV4_VHL_DEF;
         6'd16: b = tot[15:8];
         6'd17: b = tot[7:0];
         6'd22: b = IP_TTL;
         6'd23: b = IP_PROTO_ENCAP;
         6'd24: b = ck[15:8];
         6'd25: b = ck[7:0];
         6'd26: b = cfg.src_ip[31:24];
         6'd27: b = cfg.src_ip[23:16];
         6'd28: b = cfg.src_ip[15:8];
         6'd29: b = cfg.src_ip[7:0];
         6'd30: b = cfg.dst_ip[31:24];
         6'd31: b = cfg.dst_ip[23:16];
         6'd32: b = cfg.dst_ip[15:8];
         6'd33: b = cfg.dst_ip[7:0];
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

[rtl/core/ipip_front.sv]
// Front end: accepts input transactions, tracks packet state, classifies each
// byte and computes total length and checksum. Depends on ipip_pkg.
module ipip_front (
   input  logic                clock,
   input  logic                reset,
   input  ipip_pkg::cfg_type   cfg,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [7:0]          in_byte,
   input  logic                in_first,
   input  logic                in_last,
   input  logic [15:0]         in_length,
   output logic                push,
   output ipip_pkg::entry_type push_entry,
   input  logic                q_full
);
   import ipip_pkg::*;

   logic        in_packet_ff, in_packet_in;
   logic        pass_through_ff, pass_through_in;
   logic        accept;
   logic [15:0] limit;
   logic        too_long;
   logic [15:0] tot;
   logic [18:0] sum;
   logic [16:0] fold1;
   logic [16:0] fold2;

   assign in_ready = !q_full;
   assign accept   = in_valid && in_ready;

   always_comb begin
      limit    = (cfg.max_payload > LEN_CAP) ? LEN_CAP : cfg.max_payload;
      too_long = in_length > limit;
      tot      = in_length + IP_HDR_LEN;
      sum      = 19'({IPV4_VHL_DEF, 8'h00}) + 19'({IP_TTL, IP_PROTO_ENCAP}) + 19'(tot)
               + 19'(cfg.src_ip[31:16]) + 19'(cfg.src_ip[15:0])
               + 19'(cfg.dst_ip[31:16]) + 19'(cfg.dst_ip[15:0]);
      fold1    = 17'(sum[15:0]) + 17'(sum[18:16]);
      fold2    = 17'(fold1[15:0]) + 17'(fold1[16]);
   end

   always_comb begin
      in_packet_in          = in_packet_ff;
      pass_through_in       = pass_through_ff;
      push                  = 1'b0;
      push_entry.hdr        = 1'b0;
      push_entry.first_out  = 1'b0;
      push_entry.last       = in_last;
      push_entry.enc        = !pass_through_ff;
      push_entry.no_payload = (in_length == 16'd0);
      push_entry.data       = in_byte;
      push_entry.tot        = tot;
      push_entry.ck         = ~fold2[15:0];
      if (accept) begin
         if (in_first) begin
            push = 1'b1;
            if (too_long) begin
               push_entry.first_out = 1'b1;
               push_entry.enc       = 1'b0;
               in_packet_in         = !in_last;
               pass_through_in      = 1'b1;
            end else begin
               push_entry.hdr  = 1'b1;
               push_entry.enc  = 1'b1;
               pass_through_in = 1'b0;
               in_packet_in    = (in_length != 16'd0) && !in_last;
            end
         end else if (in_packet_ff) begin
            push = 1'b1;
            if (in_last) begin
               in_packet_in    = 1'b0;
               pass_through_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_packet_ff    <= 1'b0;
         pass_through_ff <= 1'b0;
      end else begin
         in_packet_ff    <= in_packet_in;
         pass_through_ff <= pass_through_in;
      end
   end

endmodule

[rtl/core/ipip_fifo.sv]
// Short queue of classified bytes between front and back end.
// Depends on ipip_pkg for the entry type.
module ipip_fifo #(
   parameter int unsigned DEPTH = ipip_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ipip_pkg::entry_type push_entry,
   input  logic                pop,
   output ipip_pkg::entry_type pop_entry,
   output logic                empty,
   output logic                full
);
   import ipip_pkg::*;

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   entry_type       mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign empty     = (count_ff == CW'(0));
   assign full      = (count_ff == CW'(DEPTH));
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign pop_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[rtl/core/ipip_back.sv]
// Back end: takes entries from the queue, emits the 34-byte outer header where
// asked, then the byte, through a registered output stage. Depends on ipip_pkg.
module ipip_back (
   input  logic                clock,
   input  logic                reset,
   input  ipip_pkg::cfg_type   cfg,
   input  ipip_pkg::entry_type q_entry,
   input  logic                q_empty,
   output logic                q_pop,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [7:0]          out_byte,
   output logic                out_first,
   output logic                out_last,
   output logic                out_enc
);
   import ipip_pkg::*;

   entry_type  cur_ff, cur_in;
   logic       cur_valid_ff, cur_valid_in;
   logic [5:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       first_ff, first_in;
   logic       last_ff, last_in;
   logic       enc_ff, enc_in;
   logic       out_free;
   logic       load;
   logic       done;

   assign out_free = !valid_ff || out_ready;
   assign load     = cur_valid_ff && out_free;

   always_comb begin
      if (!cur_ff.hdr) begin
         byte_in  = cur_ff.data;
         first_in = cur_ff.first_out;
         last_in  = cur_ff.last;
         enc_in   = cur_ff.enc;
         done     = 1'b1;
      end else if (idx_ff == HDR_BYTES) begin
         byte_in  = cur_ff.data;
         first_in = 1'b0;
         last_in  = cur_ff.last;
         enc_in   = 1'b1;
         done     = 1'b1;
      end else begin
         byte_in  = hdr_byte(idx_ff, cfg, cur_ff.tot, cur_ff.ck);
         first_in = (idx_ff == 6'd0);
         last_in  = cur_ff.no_payload && (idx_ff == HDR_BYTES - 6'd1);
         enc_in   = 1'b1;
         done     = last_in;
      end

      q_pop        = !q_empty && (!cur_valid_ff || (load && done));
      cur_in       = q_pop ? q_entry : cur_ff;
      cur_valid_in = q_pop ? 1'b1 : ((load && done) ? 1'b0 : cur_valid_ff);
      idx_in       = idx_ff;
      if (load) begin
         idx_in = done ? 6'd0 : idx_ff + 6'd1;
      end
      valid_in = load ? 1'b1 : (out_ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
         valid_ff     <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (load) begin
         byte_ff  <= byte_in;
         first_ff <= first_in;
         last_ff  <= last_in;
         enc_ff   <= enc_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_first = first_ff;
   assign out_last  = last_ff;
   assign out_enc   = enc_ff;

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> (idx_ff <= HDR_BYTES))
      else $error("header index past end");

   a_idx_hdr_only: assert property (@(posedge clock) disable iff (reset)
      (idx_ff != 6'd0) |-> (cur_valid_ff && cur_ff.hdr))
      else $error("header index without header entry");

   a_hold_entry: assert property (@(posedge clock) disable iff (reset)
      (load && !done) |=> (cur_valid_ff && $stable(cur_ff)))
      else $error("entry lost during header emission");

endmodule

[rtl/core/ipip_header_prepend_top.sv]
// Top level of the IPv4-in-IPv4 header prepend block: configuration registers,
// front end, queue and back end. Depends on ipip_pkg, ipip_front, ipip_fifo, ipip_back.
//
// Payload bytes enter one per transaction. A byte that continues a packet, or
// the first byte of a packet that is too long and passes through unchanged,
// gives one result and the block sustains one byte per cycle while the output
// is not stalled. The first byte of an encapsulated packet gives 35 results (34
// header bytes then the byte), or 34 for a zero length packet; the back end emits
// one byte per cycle while the output is not stalled, so such a byte occupies the
// output while the front end keeps accepting into a QUEUE_DEPTH entry queue until
// it is full. A result passes through the queue, the current entry register and
// the output register before it is presented. Configuration is written through
// csr_we, csr_index and csr_wdata and must only change while the block is idle.
module ipip_header_prepend_top #(
   parameter int unsigned QUEUE_DEPTH = ipip_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [ipip_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ipip_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [23:0]                       req_tdata,  // payload_byte, payload_length
   input  logic                              req_tuser,  // first_byte
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [7:0]                        rsp_tdata,  // out_byte
   output logic [1:0]                        rsp_tuser,  // out_first, encapsulated
   output logic                              rsp_tlast
);
   import ipip_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   entry_type push_entry;
   entry_type pop_entry;
   logic      push;
   logic      pop;
   logic      q_empty;
   logic      q_full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_SRC_MAC:     cfg_in.src_mac     = csr_wdata[47:0];
            CSR_DST_MAC:     cfg_in.dst_mac     = csr_wdata[47:0];
            CSR_SRC_IP:      cfg_in.src_ip      = csr_wdata[31:0];
            CSR_DST_IP:      cfg_in.dst_ip      = csr_wdata[31:0];
            CSR_MAX_PAYLOAD: cfg_in.max_payload = csr_wdata[15:0];
            default:         cfg_in             = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.src_mac     <= '0;
         cfg_ff.dst_mac     <= '0;
         cfg_ff.src_ip      <= '0;
         cfg_ff.dst_ip      <= '0;
         cfg_ff.max_payload <= LEN_CAP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ipip_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata[7:0]),
      .in_first   (req_tuser),
      .in_last    (req_tlast),
      .in_length  (req_tdata[23:8]),
      .push       (push),
      .push_entry (push_entry),
      .q_full     (q_full)
   );

   ipip_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .empty      (q_empty),
      .full       (q_full)
   );

   ipip_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_entry   (pop_entry),
      .q_empty   (q_empty),
      .q_pop     (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (rsp_tdata),
      .out_first (rsp_tuser[0]),
      .out_last  (rsp_tlast),
      .out_enc   (rsp_tuser[1])
   );

endmodule

[bench/tb_top.sv]
// Self-checking bench for ipip_header_prepend_top: a queue-fed stream driver,
// a stalling receiver and a monitor that checks every output byte against a
// behavioural predictor of the outer header insertion. Depends on ipip_pkg.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ipip_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int ITEMS_PER_PHASE = 35;
   localparam int RANDOM_PHASES = 4;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic [7:0]  data;
      logic        first;
      logic        last;
      logic [15:0] len;
   } payload_item_type;

   typedef struct packed {
      logic [7:0] data;
      logic       first;
      logic       last;
      logic       enc;
   } out_byte_type;

   typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE} sink_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [23:0]           req_tdata = '0;  // payload_byte, payload_length
   logic                  req_tuser = 1'b0;  // first_byte
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;  // out_byte
   logic [1:0]            rsp_tuser;  // out_first, encapsulated
   logic                  rsp_tlast;

   ipip_header_prepend_top dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state and configuration copy
   logic [47:0] cfg_src_mac = '0;
   logic [47:0] cfg_dst_mac = '0;
   logic [31:0] cfg_src_ip = '0;
   logic [31:0] cfg_dst_ip = '0;
   logic [15:0] cfg_max_payload = 16'd65501;
   logic        in_pkt = 1'b0;
   logic        pass_thru = 1'b0;

   payload_item_type ingress_q[$];
   out_byte_type     egress_q[$];
   int               pushed_count = 0;
   int               accepted_count = 0;
   int               errors = 0;
   int               cycles = 0;
   int               hold_req = 0;

   function automatic logic [15:0] payload_limit();
      return (cfg_max_payload > LEN_CAP) ? LEN_CAP : cfg_max_payload;
   endfunction

   function automatic void expect_byte(logic [7:0] d, logic f, logic l, logic e);
      out_byte_type o;
      o.data = d;
      o.first = f;
      o.last = l;
      o.enc = e;
      egress_q.push_back(o);
   endfunction

   function automatic void encapsulate_item(payload_item_type it);
      logic [15:0] tot;
      logic [15:0] ck;
      logic [31:0] sum;
      logic [7:0]  hdr [0:33];
      if (it.first) begin
         if (it.len > payload_limit()) begin
            expect_byte(it.data, 1'b1, it.last, 1'b0);
            in_pkt = !it.last;
            pass_thru = 1'b1;
            return;
         end
         tot = IP_HDR_LEN + it.len;
         sum = 32'h4500 + tot + 32'h4004 + cfg_src_ip[31:16] + cfg_src_ip[15:0]
               + cfg_dst_ip[31:16] + cfg_dst_ip[15:0];
         sum = sum[15:0] + sum[31:16];
         sum = sum[15:0] + sum[31:16];
         ck = ~sum[15:0];
         for (int i = 0; i < 6; i++) begin
            hdr[i] = cfg_dst_mac[47 - 8*i -: 8];
            hdr[6 + i] = cfg_src_mac[47 - 8*i -: 8];
         end
         hdr[12] = 8'h08;
         hdr[13] = 8'h00;
         hdr[14] = 8'h45;
         hdr[15] = 8'h00;
         hdr[16] = tot[15:8];
         hdr[17] = tot[7:0];
         hdr[18] = 8'h00;
         hdr[19] = 8'h00;
         hdr[20] = 8'h00;
         hdr[21] = 8'h00;
         hdr[22] = 8'd64;
         hdr[23] = 8'd4;
         hdr[24] = ck[15:8];
         hdr[25] = ck[7:0];
         for (int i = 0; i < 4; i++) begin
            hdr[26 + i] = cfg_src_ip[31 - 8*i -: 8];
            hdr[30 + i] = cfg_dst_ip[31 - 8*i -: 8];
         end
         for (int i = 0; i < 34; i++)
            expect_byte(hdr[i], i == 0, (it.len == 0) && (i == 33), 1'b1);
         pass_thru = 1'b0;
         if (it.len == 0) begin
            in_pkt = 1'b0;
         end else begin
            expect_byte(it.data, 1'b0, it.last, 1'b1);
            in_pkt = !it.last;
         end
      end else if (in_pkt) begin
         expect_byte(it.data, 1'b0, it.last, !pass_thru);
         if (it.last) begin
            in_pkt = 1'b0;
            pass_thru = 1'b0;
         end
      end
   endfunction

   // sender: bursts of random length separated by random gaps
   payload_item_type held;
   int               burst_left = 0;
   int               gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            encapsulate_item(held);
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (ingress_q.size() > 0) begin
               held = ingress_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {held.len, held.data};
               req_tuser <= held.first;
               req_tlast <= held.last;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 30);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver: changing stall pattern plus requested long hold-offs
   sink_mode_type sink_mode = READY_ALWAYS;
   int            mode_left = 0;
   int            hold_left = 0;
   int            hold_seen = 0;
   logic          ready_nxt;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            ready_nxt = 1'b0;
         end else begin
            if (mode_left == 0) begin
               sink_mode = sink_mode_type'($urandom_range(0, 2));
               mode_left = $urandom_range(20, 150);
            end else begin
               mode_left--;
            end
            case (sink_mode)
               READY_ALWAYS: ready_nxt = 1'b1;
               READY_COIN:   ready_nxt = 1'($urandom_range(0, 1));
               default:      ready_nxt = ($urandom_range(0, 3) == 0);
            endcase
         end
         rsp_tready <= ready_nxt;
      end
   end

   out_byte_type want;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (egress_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected output byte %h first %b last %b enc %b",
                        rsp_tdata, rsp_tuser[0], rsp_tlast, rsp_tuser[1]);
         end else begin
            want = egress_q.pop_front();
            if (rsp_tdata !== want.data || rsp_tuser[0] !== want.first ||
                rsp_tlast !== want.last || rsp_tuser[1] !== want.enc) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: expected %h/%b/%b/%b got %h/%b/%b/%b (byte/first/last/enc)",
                           want.data, want.first, want.last, want.enc,
                           rsp_tdata, rsp_tuser[0], rsp_tlast, rsp_tuser[1]);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic void push_item(logic [7:0] d, logic f, logic l, logic [15:0] n);
      payload_item_type it;
      it.data = d;
      it.first = f;
      it.last = l;
      it.len = n;
      ingress_q.push_back(it);
      pushed_count++;
   endfunction

   task automatic write_reg(csr_idx_type idx, logic [47:0] v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      case (idx)
         CSR_SRC_MAC: cfg_src_mac = v;
         CSR_DST_MAC: cfg_dst_mac = v;
         CSR_SRC_IP:  cfg_src_ip = v[31:0];
         CSR_DST_IP:  cfg_dst_ip = v[31:0];
         default:     cfg_max_payload = v[15:0];
      endcase
   endtask

   task automatic set_config(logic [47:0] smac, logic [47:0] dmac, logic [31:0] sip,
                             logic [31:0] dip, logic [15:0] maxp);
      write_reg(CSR_SRC_MAC, smac);
      write_reg(CSR_DST_MAC, dmac);
      write_reg(CSR_SRC_IP, {16'h0, sip});
      write_reg(CSR_DST_IP, {16'h0, dip});
      write_reg(CSR_MAX_PAYLOAD, {32'h0, maxp});
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_idle();
      while (accepted_count != pushed_count || egress_q.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic gen_packet();
      int          kind;
      int          nb;
      logic        open;
      logic [15:0] lim;
      logic [15:0] n;
      lim = payload_limit();
      kind = $urandom_range(0, 99);
      open = 1'b0;
      if (kind >= 93) begin
         push_item(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)),
                   16'($urandom_range(0, 65535)));
         return;
      end
      if (kind < 60) begin
         n = 16'($urandom_range(1, 6));
         nb = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : n;
      end else if (kind < 70) begin
         n = 16'($urandom_range(lim + 1, 65535));
         nb = $urandom_range(1, 4);
      end else if (kind < 78) begin
         n = 16'd0;
         nb = 1;
      end else if (kind < 86) begin
         n = 16'($urandom_range(0, lim));
         nb = $urandom_range(1, 3);
      end else begin
         n = 16'($urandom_range(1, 6));
         nb = $urandom_range(1, 3);
         open = 1'b1;
      end
      for (int i = 0; i < nb; i++)
         push_item(8'($urandom_range(0, 255)), i == 0,
                   (n == 0) ? 1'($urandom_range(0, 1)) : ((i == nb - 1) && !open),
                   (i == 0) ? n : 16'($urandom_range(0, 65535)));
   endtask

   initial begin
      logic [15:0] maxp;
      int          phase_start;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset configuration: largest encapsulated length and first oversize
      push_item(8'hA5, 1'b1, 1'b1, 16'd1);
      push_item(8'h00, 1'b1, 1'b0, 16'd65501);
      push_item(8'hFF, 1'b0, 1'b1, 16'h5AA5);
      push_item(8'h3C, 1'b1, 1'b1, 16'd65502);
      wait_idle();

      // all ones: limit clamps, zero length, strays, abandoned packet
      set_config('1, '1, '1, '1, 16'hFFFF);
      push_item(8'hFF, 1'b1, 1'b0, 16'hFFFF);
      push_item(8'h00, 1'b0, 1'b1, 16'h0000);
      push_item(8'h77, 1'b1, 1'b1, 16'd0);
      push_item(8'h12, 1'b0, 1'b1, 16'd7);
      push_item(8'h81, 1'b1, 1'b0, 16'd3);
      push_item(8'h82, 1'b0, 1'b0, 16'd0);
      push_item(8'h91, 1'b1, 1'b0, 16'd2);
      push_item(8'h92, 1'b0, 1'b1, 16'd0);
      push_item(8'h44, 1'b1, 1'b0, 16'd0);
      push_item(8'h45, 1'b0, 1'b1, 16'd1);
      wait_idle();

      // all zeros: every non-empty packet passes through
      set_config('0, '0, '0, '0, 16'd0);
      push_item(8'h10, 1'b1, 1'b1, 16'd0);
      push_item(8'h20, 1'b1, 1'b0, 16'd1);
      push_item(8'h21, 1'b0, 1'b0, 16'd0);
      push_item(8'h22, 1'b0, 1'b1, 16'd0);
      push_item(8'h30, 1'b1, 1'b1, 16'd1);
      wait_idle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case ($urandom_range(0, 3))
            0:       maxp = 16'd65501;
            1:       maxp = 16'hFFFF;
            2:       maxp = 16'($urandom_range(0, 8));
            default: maxp = 16'($urandom_range(0, 65535));
         endcase
         set_config(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                    $urandom, $urandom, maxp);
         hold_req++;
         phase_start = pushed_count;
         while (pushed_count - phase_start < ITEMS_PER_PHASE)
            gen_packet();
         wait_idle();
      end

      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
